@@ rtl/lrfu_pkg.sv @@
package lrfu_pkg;

  localparam int unsigned IdW    = 64;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned CapW   = 11;
  localparam int unsigned RateW  = 16;
  localparam logic [ScoreW-1:0] OneQ24 = 32'h0100_0000;

  localparam logic RegCapacity = 1'b0;
  localparam logic RegDecay    = 1'b1;

  typedef struct packed {
    logic start;
    logic scan;
    logic heap_op;
  } lrfu_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic heap_done;
  } lrfu_status_t;

  // 2^-(i/depth) in Q0.24, series form matching the integer build
  function automatic logic [ScoreW-1:0] frac_entry(input int unsigned i,
                                                   input int unsigned depth);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [127:0] t;
    x = (64'(i) << 32) / 64'(depth);
    t = 128'(x) * 128'(64'd2977044472);
    y = t[95:32];
    term = 64'h1_0000_0000;
    sum = term;
    for (int k = 1; k <= 13; k++) begin
      t = 128'(term) * 128'(y);
      term = t[95:32] / 64'(k);
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = (sum + 64'd128) >> 8;
    return sum[ScoreW-1:0];
  endfunction

endpackage

@@ rtl/lrfu_ctrl.sv @@
module lrfu_ctrl import lrfu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  lrfu_status_t status,
  output lrfu_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HEAP = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) state_next = S_HEAP;
      end
      S_HEAP: begin
        cmd.heap_op = 1'b1;
        if (status.heap_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/lrfu_datapath.sv @@
module lrfu_datapath import lrfu_pkg::*; #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned FRAC_TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  lrfu_cmd_t         cmd,
  output lrfu_status_t      status,
  input  logic [IdW-1:0]    object_id,
  input  logic [CapW-1:0]   capacity_reg,
  input  logic [RateW-1:0]  decay_reg,
  output logic              result_valid,
  output logic              hit,
  output logic              evicted_valid,
  output logic [IdW-1:0]    evicted_id
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned FW = $clog2(FRAC_TABLE_DEPTH);

  typedef enum logic [14:0] {
    H_RD_ENTRY = 15'h0001, H_RD_WAIT = 15'h0002, H_DECAY1 = 15'h0004,
    H_DECAY2   = 15'h0008, H_EVICT0  = 15'h0010, H_EVICT1 = 15'h0020,
    H_EVICT2   = 15'h0040, H_INSERT  = 15'h0080, H_SK_RD  = 15'h0100,
    H_SK_WAIT  = 15'h0200, H_SK_CMP  = 15'h0400, H_UP_RD  = 15'h0800,
    H_UP_WAIT  = 15'h1000, H_UP_CMP  = 15'h2000, H_DONE   = 15'h4000
  } hstate_t;

  // per-slot storage
  logic [IdW-1:0]    ids    [CAPACITY];
  logic [ScoreW-1:0] scores [CAPACITY];
  logic [31:0]       stamps [CAPACITY];
  logic [AW-1:0]     heap   [CAPACITY];
  logic [AW-1:0]     hpos   [CAPACITY];

  logic [OW-1:0]  occupancy;
  logic [31:0]    tick_count;
  logic [IdW-1:0] req_id;
  logic [OW-1:0]  scan_idx;
  logic           found;
  logic [AW-1:0]  slot;
  logic [IdW-1:0] id_rd;
  logic [AW-1:0]  cmp_idx;
  logic           cmp_valid;
  hstate_t        hs;
  logic           sink_after_rise;

  // decay
  logic [ScoreW-1:0] score_rd, stamp_rd, tab_q;
  logic [47:0] expo;
  logic [63:0] prod;

  // heap walk registers
  logic [AW-1:0] p;          // current position
  logic [AW-1:0] sp, sl, sr; // slots at p, left, right
  logic [ScoreW-1:0] vp, vl, vr;
  logic [1:0] rd_phase;

  logic [OW-1:0] cap_eff;
  always_comb begin
    if (capacity_reg == '0) cap_eff = OW'(1);
    else if (32'(capacity_reg) > CAPACITY) cap_eff = OW'(CAPACITY);
    else cap_eff = OW'(capacity_reg);
  end

  logic [ScoreW-1:0] ftab [FRAC_TABLE_DEPTH];
  always_comb begin
    for (int i = 0; i < FRAC_TABLE_DEPTH; i++) ftab[i] = frac_entry(i, FRAC_TABLE_DEPTH);
  end

  logic [OW:0] lpos, rpos;
  assign lpos = (OW+1)'({p, 1'b1});
  assign rpos = (OW+1)'({p, 1'b0}) + (OW+1)'(2);

  logic [15:0] frac;
  logic [31:0] fidx;
  logic [FW-1:0] tidx;
  logic [31:0] nsh;
  logic [64:0] dec_sum;
  assign frac = expo[15:0];
  assign fidx = (32'(frac) * 32'(FRAC_TABLE_DEPTH)) >> 16;
  assign tidx = FW'(fidx);
  assign nsh  = 32'(expo[47:16]) + 32'd24;
  assign dec_sum = (nsh >= 32'd64) ? 65'(OneQ24) : 65'(prod >> nsh[5:0]) + 65'(OneQ24);

  logic [AW-1:0] parent;
  assign parent = AW'((32'(p) - 32'd1) >> 1);

  // scan compares the id read in the previous cycle
  logic id_match;
  logic scan_fin;
  assign id_match = cmp_valid && (id_rd == req_id);
  assign scan_fin = id_match || (scan_idx >= occupancy);

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      result_valid <= 1'b0;
    end else begin
      status <= '{scan_done: cmd.scan & scan_fin,
                  heap_done: cmd.heap_op & (hs == H_DONE)};
      result_valid <= cmd.heap_op & (hs == H_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      tick_count <= '0;
      hs <= H_RD_ENTRY;
      rd_phase <= 2'd0;
    end else begin
      if (cmd.start) begin
        req_id <= object_id;
        tick_count <= tick_count + 32'd1;
        scan_idx <= '0;
        found <= 1'b0;
        cmp_valid <= 1'b0;
        hs <= H_RD_ENTRY;
      end
      // linear search, one slot per cycle: registered read, compare next cycle
      if (cmd.scan) begin
        id_rd <= ids[AW'(scan_idx)];
        cmp_idx <= AW'(scan_idx);
        cmp_valid <= (scan_idx < occupancy) && !id_match && !found;
        if (scan_idx < occupancy) scan_idx <= scan_idx + OW'(1);
        if (id_match) begin
          found <= 1'b1;
          slot <= cmp_idx;
        end
      end
      if (cmd.heap_op) begin
        unique case (hs)
          H_RD_ENTRY: begin
            hit <= found;
            evicted_valid <= 1'b0;
            evicted_id <= '0;
            if (found) hs <= H_RD_WAIT;
            else if (occupancy >= cap_eff) hs <= H_EVICT0;
            else begin
              slot <= AW'(occupancy);
              hs <= H_INSERT;
            end
            score_rd <= scores[slot];
            stamp_rd <= stamps[slot];
          end
          H_RD_WAIT: begin
            expo <= 48'(decay_reg) * 48'(tick_count - stamp_rd);
            hs <= H_DECAY1;
          end
          H_DECAY1: begin
            tab_q <= ftab[tidx];
            hs <= H_DECAY2;
          end
          H_DECAY2: begin
            if (rd_phase == 2'd0) begin
              prod <= 64'(score_rd) * 64'(tab_q);
              rd_phase <= 2'd1;
            end else begin
              rd_phase <= 2'd0;
              scores[slot] <= (dec_sum > 65'h0_FFFF_FFFF) ? '1 : dec_sum[ScoreW-1:0];
              stamps[slot] <= tick_count;
              p <= hpos[slot];
              sink_after_rise <= 1'b0;
              hs <= H_SK_RD;
            end
          end
          H_EVICT0: begin
            slot <= heap[AW'(0)];
            sp <= heap[AW'(occupancy - OW'(1))];
            hs <= H_EVICT1;
          end
          H_EVICT1: begin
            evicted_valid <= 1'b1;
            evicted_id <= ids[slot];
            heap[AW'(0)] <= sp;
            hpos[sp] <= '0;
            occupancy <= occupancy - OW'(1);
            p <= '0;
            sink_after_rise <= 1'b1;
            hs <= H_SK_RD;
          end
          H_EVICT2, H_INSERT: begin
            ids[slot] <= req_id;
            scores[slot] <= OneQ24;
            stamps[slot] <= tick_count;
            heap[AW'(occupancy)] <= slot;
            hpos[slot] <= AW'(occupancy);
            p <= AW'(occupancy);
            occupancy <= occupancy + OW'(1);
            hs <= H_UP_RD;
          end
          H_SK_RD: begin
            // gather p, left, right slots then scores in three read phases
            unique case (rd_phase)
              2'd0: begin sp <= heap[p]; rd_phase <= 2'd1; end
              2'd1: begin
                sl <= heap[AW'(lpos)];
                sr <= heap[AW'(rpos)];
                vp <= scores[sp];
                rd_phase <= 2'd2;
              end
              default: begin
                vl <= scores[sl];
                vr <= scores[sr];
                rd_phase <= 2'd0;
                hs <= H_SK_CMP;
              end
            endcase
          end
          H_SK_CMP: begin
            if ((lpos < (OW+1)'(occupancy)) && (vl < vp) &&
                !((rpos < (OW+1)'(occupancy)) && (vr < vl))) begin
              heap[p] <= sl; hpos[sl] <= p;
              heap[AW'(lpos)] <= sp; hpos[sp] <= AW'(lpos);
              p <= AW'(lpos);
              hs <= H_SK_RD;
            end else if ((rpos < (OW+1)'(occupancy)) && (vr < vp)) begin
              heap[p] <= sr; hpos[sr] <= p;
              heap[AW'(rpos)] <= sp; hpos[sp] <= AW'(rpos);
              p <= AW'(rpos);
              hs <= H_SK_RD;
            end else hs <= sink_after_rise ? H_EVICT2 : H_DONE;
          end
          H_UP_RD: begin
            if (p == '0) hs <= H_DONE;
            else begin
              sp <= heap[p];
              sl <= heap[parent];
              hs <= H_UP_WAIT;
            end
          end
          H_UP_WAIT: begin
            vp <= scores[sp];
            vl <= scores[sl];
            hs <= H_UP_CMP;
          end
          H_UP_CMP: begin
            if (vp < vl) begin
              heap[p] <= sl; hpos[sl] <= p;
              heap[parent] <= sp; hpos[sp] <= parent;
              p <= parent;
              hs <= H_UP_RD;
            end else hs <= H_DONE;
          end
          H_DONE: begin
            hs <= H_RD_ENTRY;
          end
          default: hs <= H_DONE;
        endcase
      end
    end
  end

endmodule

@@ rtl/lrfu_replacement_engine_core.sv @@
// LRFU replacement engine, one request in flight. A request runs a linear id scan over the
// resident slots, then heap work, then the result strobe; heap work is an insert that rises
// on a miss with room, a score decay and a sink on a hit, and on an eviction a sink of the
// moved last entry, then an insert that rises. A new request is taken only once busy falls
// after the strobe; the linear id scan dominates.
// Reset (rst, synchronous): occupancy, tick count cleared, registers at defaults; no stall.
module lrfu_replacement_engine_core import lrfu_pkg::*; #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned FRAC_TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [IdW-1:0]   object_id,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             result_strobe,
  output logic             hit,
  output logic             evicted_valid,
  output logic [IdW-1:0]   evicted_id
);

  lrfu_cmd_t    cmd;
  lrfu_status_t status;
  logic [CapW-1:0]  capacity_reg;
  logic [RateW-1:0] decay_reg;

  assign cfg_ready = 1'b1;

  // config beats
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_reg <= CapW'(1024);
      decay_reg <= RateW'(655);
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        RegCapacity: capacity_reg <= cfg_data[CapW-1:0];
        RegDecay:    decay_reg <= cfg_data[RateW-1:0];
        default: ;
      endcase
    end
  end

  lrfu_ctrl u_ctrl (
    .clk, .rst, .start, .status, .cmd, .busy
  );

  lrfu_datapath #(.CAPACITY(CAPACITY), .FRAC_TABLE_DEPTH(FRAC_TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .status, .object_id, .capacity_reg, .decay_reg,
    .result_valid(result_strobe), .hit, .evicted_valid, .evicted_id
  );

endmodule

@@ sim/lrfu_replacement_engine_core_test.sv @@
`timescale 1ns / 100ps

module lrfu_replacement_engine_core_test;
  import lrfu_pkg::*;

  localparam int unsigned Slots = 1024;
  localparam int unsigned FracDepth = 1024;
  localparam logic [63:0] Ln2Q32 = 64'd2977044472;

  // expected outcome of one lookup
  typedef struct {
    logic hit;
    logic evicted_valid;
    logic [IdW-1:0] evicted_id;
  } lookup_outcome_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [IdW-1:0] object_id;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;
  logic result_strobe;
  logic hit;
  logic evicted_valid;
  logic [IdW-1:0] evicted_id;

  lrfu_replacement_engine_core #(
    .CAPACITY(Slots),
    .FRAC_TABLE_DEPTH(FracDepth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .object_id(object_id),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .hit(hit),
    .evicted_valid(evicted_valid),
    .evicted_id(evicted_id)
  );

  // ---------------------------------------------------------------
  // Cache model: slots, scores, stamps and a min-heap over slots
  // ---------------------------------------------------------------
  logic [31:0] pow2_frac [FracDepth];
  logic [10:0] mdl_capacity;
  logic [15:0] mdl_rate;
  logic [IdW-1:0] slot_id [Slots];
  logic [31:0] slot_score [Slots];
  logic [31:0] slot_stamp [Slots];
  int unsigned heap_slot [Slots];
  int unsigned slot_pos [Slots];
  int unsigned resident;
  logic [31:0] now_tick;

  lookup_outcome_t expected_lookups[$];
  logic [IdW-1:0] pending_ids[$];

  int errors;
  int lookups_seen;
  int hits_seen;
  int evicts_seen;
  bit quiet;        // no idle bursts
  bit hold_drain;   // sender waits until all outcomes are back
  int gap;

  // 2^-(i/depth) in Q0.24 via alternating series in Q0.32
  task automatic build_pow2_table();
    logic [63:0] x, y, term, sum;
    for (int i = 0; i < FracDepth; i++) begin
      x = (64'(i) << 32) / 64'(FracDepth);
      y = (x * Ln2Q32) >> 32;
      term = 64'h1_0000_0000;
      sum = term;
      for (int k = 1; k <= 13; k++) begin
        term = ((term * y) >> 32) / 64'(k);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      pow2_frac[i] = 32'((sum + 64'd128) >> 8);
    end
  endtask

  task automatic swap_heap(int unsigned a, int unsigned b);
    int unsigned sa, sb;
    sa = heap_slot[a];
    sb = heap_slot[b];
    heap_slot[a] = sb;
    slot_pos[sb] = a;
    heap_slot[b] = sa;
    slot_pos[sa] = b;
  endtask

  task automatic heap_rise(int unsigned p);
    int unsigned up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (slot_score[heap_slot[p]] < slot_score[heap_slot[up]]) begin
        swap_heap(p, up);
        p = up;
      end else break;
    end
  endtask

  task automatic heap_sink(int unsigned p);
    int unsigned best, l, r;
    forever begin
      best = p;
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l < resident && slot_score[heap_slot[l]] < slot_score[heap_slot[best]]) best = l;
      if (r < resident && slot_score[heap_slot[r]] < slot_score[heap_slot[best]]) best = r;
      if (best == p) break;
      swap_heap(p, best);
      p = best;
    end
  endtask

  function automatic logic [31:0] refreshed_score(logic [31:0] score, logic [31:0] elapsed);
    logic [63:0] e, n, idx, prod, dec, res;
    e = 64'(mdl_rate) * 64'(elapsed);
    n = e >> 16;
    idx = ((e & 64'hFFFF) * 64'(FracDepth)) >> 16;
    if (idx >= FracDepth) idx = FracDepth - 1;
    prod = 64'(score) * 64'(pow2_frac[idx]);
    dec = (n + 24 >= 64) ? 64'd0 : (prod >> (n + 24));
    res = dec + 64'(OneQ24);
    return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
  endfunction

  task automatic predict_lookup(logic [IdW-1:0] id);
    lookup_outcome_t o;
    int unsigned cap, slot, last;
    bit found;
    cap = mdl_capacity;
    if (cap < 1) cap = 1;
    if (cap > Slots) cap = Slots;
    now_tick = now_tick + 1;
    o = '{1'b0, 1'b0, '0};
    found = 0;
    slot = 0;
    for (int s = 0; s < resident; s++) begin
      if (slot_id[s] == id) begin
        slot = s;
        found = 1;
        break;
      end
    end
    if (found) begin
      slot_score[slot] = refreshed_score(slot_score[slot], now_tick - slot_stamp[slot]);
      slot_stamp[slot] = now_tick;
      heap_sink(slot_pos[slot]);
      o.hit = 1'b1;
    end else begin
      if (resident >= cap) begin
        // evict the root; last heap entry takes its place and sinks
        slot = heap_slot[0];
        o.evicted_valid = 1'b1;
        o.evicted_id = slot_id[slot];
        last = heap_slot[resident - 1];
        heap_slot[0] = last;
        slot_pos[last] = 0;
        resident--;
        heap_sink(0);
      end else slot = resident;
      slot_id[slot] = id;
      slot_score[slot] = OneQ24;
      slot_stamp[slot] = now_tick;
      heap_slot[resident] = slot;
      slot_pos[slot] = resident;
      resident++;
      heap_rise(resident - 1);
    end
    expected_lookups.push_back(o);
  endtask

  // ---------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("timeout at %0t", $realtime);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------
  // Driver: one lookup beat at a time, sent only when the engine is free
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      if (start && !busy) predict_lookup(object_id);
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending_ids.size() == 0 || (hold_drain && expected_lookups.size() != 0)) begin
          start <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 14) - 1;
          start <= 1'b0;
        end else begin
          object_id <= pending_ids.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: every strobe must match the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    lookup_outcome_t e;
    if (!rst && result_strobe) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result hit=%0b ev=%0b id=%h", $realtime, hit,
                 evicted_valid, evicted_id);
        errors++;
      end else begin
        e = expected_lookups.pop_front();
        lookups_seen++;
        if (e.hit) hits_seen++;
        if (e.evicted_valid) evicts_seen++;
        if (hit !== e.hit) begin
          $display("%0t: hit exp %0b got %0b", $realtime, e.hit, hit);
          errors++;
        end
        if (evicted_valid !== e.evicted_valid) begin
          $display("%0t: evicted_valid exp %0b got %0b", $realtime, e.evicted_valid,
                   evicted_valid);
          errors++;
        end
        if (evicted_id !== e.evicted_id) begin
          $display("%0t: evicted_id exp %h got %h", $realtime, e.evicted_id, evicted_id);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------
  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegCapacity) mdl_capacity = data[10:0];
    else mdl_rate = data[15:0];
  endtask

  // all lookups issued and answered, engine idle
  task automatic drain();
    wait (pending_ids.size() == 0 && !start && expected_lookups.size() == 0);
    repeat (50) @(posedge clk);
    wait (!busy);
  endtask

  // random phase: mostly reused ids from a pool of 1.5x capacity plus two, at most 60
  task automatic run_phase(logic [31:0] cap_data, logic [31:0] rate_data, int n);
    logic [IdW-1:0] pool[$];
    int psize;
    write_reg(RegCapacity, cap_data);
    write_reg(RegDecay, rate_data);
    psize = cap_data[10:0] + cap_data[10:0] / 2 + 2;
    if (psize > 60) psize = 60;
    for (int i = 0; i < psize; i++) pool.push_back({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) pending_ids.push_back({$urandom, $urandom});
      else pending_ids.push_back(pool[$urandom_range(0, psize - 1)]);
    end
  endtask

  initial begin
    logic [IdW-1:0] ids[$];
    rst = 1'b1;
    start = 1'b0;
    object_id = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    lookups_seen = 0;
    hits_seen = 0;
    evicts_seen = 0;
    quiet = 0;
    hold_drain = 0;
    build_pow2_table();
    mdl_capacity = 11'd1024;
    mdl_rate = 16'd655;
    resident = 0;
    now_tick = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: small cache, fill, hits, evictions, extreme ids
    write_reg(RegCapacity, 32'd4);
    write_reg(RegDecay, 32'd655);
    ids = '{64'h0, '1, 64'h0, 64'h1, 64'h2, 64'h0, 64'h3, 64'h8000_0000_0000_0000,
            64'h1, 64'h0, '1, 64'h2, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0, 64'h0, 64'h3, '1, 64'h1, 64'h4};
    foreach (ids[i]) pending_ids.push_back(ids[i]);
    drain();

    // capacity zero (upper data bits ignored) acts as one; no decay
    run_phase(32'hFFFF_F800, 32'd0, 150);
    drain();
    // fastest decay; sender stalls mid-phase until everything is back
    run_phase(32'd8, 32'd65535, 200);
    wait (pending_ids.size() < 100);
    hold_drain = 1;
    wait (expected_lookups.size() == 0);
    repeat ($urandom_range(1, 10)) @(posedge clk);
    hold_drain = 0;
    drain();
    run_phase(32'd16, 32'($urandom_range(0, 65535)), 200);
    drain();
    run_phase(32'd3, 32'd1, 200);
    drain();
    run_phase(32'd32, 32'hFFFF_0000 | 32'd655, 200);
    drain();
    // capacity lowered below occupancy: occupancy holds
    run_phase(32'd5, 32'($urandom_range(0, 65535)), 200);
    drain();
    run_phase(32'd12, 32'($urandom_range(0, 4000)), 200);
    drain();
    // oversized value clamps to the full cache; last stretch runs without idling
    run_phase(32'd2047, 32'($urandom_range(0, 65535)), 150);
    drain();
    quiet = 1;
    run_phase(32'd1024, 32'd655, 280);
    drain();

    $display("lookups checked: %0d  hits: %0d  evictions: %0d", lookups_seen, hits_seen,
             evicts_seen);
    $display("capacities 1..1024 with clamping, decay rates 0..65535, idle and stall mix");
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("errors: %0d  outstanding: %0d", errors, expected_lookups.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
